@@ src/lti_pkg.sv @@
// ----------------------------------------------------------------------------
// lti_pkg
// Shared types and constants for the looped timeline interpolator.
// ----------------------------------------------------------------------------
package lti_pkg;

    localparam int unsigned ROWS     = 256;
    localparam int unsigned ROW_AW   = $clog2(ROWS);
    localparam int unsigned NF       = 7;
    localparam int unsigned FW       = 3;
    localparam int unsigned VAL_AW   = ROW_AW + FW;
    localparam int unsigned VW       = 48;
    localparam int unsigned TW       = 32;
    localparam int unsigned NOW_W    = 64;
    localparam int unsigned RC_W     = 9;
    localparam int unsigned ST_W     = 3;
    localparam int unsigned CFG_AW   = 8;
    localparam int unsigned CFG_DW   = 16;
    localparam int unsigned DIF_W    = VW + 1;
    localparam int unsigned DL_W     = 24;
    localparam int unsigned PROD_W   = TW + DIF_W;
    localparam int unsigned CNT_W    = 7;

    localparam logic [1:0] FUNC_LOAD_T = 2'd0;
    localparam logic [1:0] FUNC_LOAD_V = 2'd1;
    localparam logic [1:0] FUNC_START  = 2'd2;
    localparam logic [1:0] FUNC_READ   = 2'd3;

    localparam logic [2:0] MEAS_OK     = 3'd0;
    localparam logic [2:0] MEAS_UNAVL  = 3'd1;
    localparam logic [2:0] MEAS_WARMUP = 3'd2;
    localparam logic [2:0] MEAS_STALE  = 3'd3;
    localparam logic [2:0] MEAS_ERROR  = 3'd4;
    localparam logic [2:0] MEAS_NS     = 3'd5;

    localparam logic [2:0] ROW_OK      = 3'd0;
    localparam logic [2:0] ROW_WARMUP  = 3'd1;
    localparam logic [2:0] ROW_STALE   = 3'd2;

    localparam logic [2:0] SLOT_NONE   = 3'd7;
    localparam logic [2:0] FIELD_LAST  = 3'd6;

    localparam logic [CFG_AW-1:0] REG_ROW_COUNT = 8'd0;
    localparam logic [CFG_AW-1:0] REG_INTERP    = 8'd1;
    localparam logic [CFG_AW-1:0] REG_MASK      = 8'd2;
    localparam logic [CFG_AW-1:0] REG_SENSOR    = 8'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_PER_RD, S_PER_WT, S_PER_CHK, S_MOD, S_SCAN_INIT, S_SCAN,
        S_R0, S_R1, S_R2, S_V0, S_V1, S_V2, S_MUL0, S_MUL1, S_DIV, S_FIN, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_IDLE, OP_PER_RD, OP_PER_WT, OP_PER_CHK, OP_MOD, OP_SCAN_INIT, OP_SCAN,
        OP_R0, OP_R1, OP_R2, OP_V0, OP_V1, OP_V2, OP_MUL0, OP_MUL1, OP_DIV,
        OP_FIN, OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic started;
        logic period_zero;
        logic mod_done;
        logic scan_done;
        logic div_done;
        logic interp_go;
        logic last_field;
    } t_sts;

endpackage

@@ src/lti_if.sv @@
// ----------------------------------------------------------------------------
// lti_in_if, lti_out_if, lti_cfg_if
// Valid/ready channels of the looped timeline interpolator.
// ----------------------------------------------------------------------------
interface lti_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic [7:0]          row_index;
    logic [2:0]          field_slot;
    logic [31:0]         row_time_ms;
    logic [2:0]          row_status_code;
    logic signed [47:0]  field_value;
    logic [63:0]         now_ms;
    modport source (output valid, func, row_index, field_slot, row_time_ms,
                     row_status_code, field_value, now_ms, input ready);
    modport sink (input valid, func, row_index, field_slot, row_time_ms,
                  row_status_code, field_value, now_ms, output ready);
endinterface

interface lti_out_if;
    logic                valid;
    logic                ready;
    logic [2:0]          field_id;
    logic [2:0]          meas_code;
    logic signed [47:0]  measured_value;
    logic [63:0]         timestamp_ms;
    logic [7:0]          source_tag;
    logic                last;
    modport source (output valid, field_id, meas_code, measured_value, timestamp_ms,
                     source_tag, last, input ready);
    modport sink (input valid, field_id, meas_code, measured_value, timestamp_ms,
                  source_tag, last, output ready);
endinterface

interface lti_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ src/lti_ctrl.sv @@
// ----------------------------------------------------------------------------
// lti_ctrl
// Sequencer that steps the datapath through one read.
// ----------------------------------------------------------------------------
module lti_ctrl
    import lti_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_fire,
    input  logic [1:0] i_in_func,
    input  logic       i_out_fire,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_in_ready,
    output logic       o_out_valid
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_fire && i_in_func == FUNC_READ) begin
                    n_state = i_sts.started ? S_PER_RD : S_OUT;
                end
            end
            S_PER_RD:    n_state = S_PER_WT;
            S_PER_WT:    n_state = S_PER_CHK;
            S_PER_CHK:   n_state = i_sts.period_zero ? S_R0 : S_MOD;
            S_MOD:       if (i_sts.mod_done) n_state = S_SCAN_INIT;
            S_SCAN_INIT: n_state = S_SCAN;
            S_SCAN:      if (i_sts.scan_done) n_state = S_R0;
            S_R0:        n_state = S_R1;
            S_R1:        n_state = S_R2;
            S_R2:        n_state = S_V0;
            S_V0:        n_state = S_V1;
            S_V1:        n_state = S_V2;
            S_V2:        n_state = i_sts.interp_go ? S_MUL0 : S_OUT;
            S_MUL0:      n_state = S_MUL1;
            S_MUL1:      n_state = S_DIV;
            S_DIV:       if (i_sts.div_done) n_state = S_FIN;
            S_FIN:       n_state = S_OUT;
            S_OUT: begin
                if (i_out_fire) begin
                    n_state = (!i_sts.started || i_sts.last_field) ? S_IDLE : S_V0;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.op    = OP_IDLE;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.op   = OP_IDLE;
            end
            S_PER_RD:    o_cmd.op = OP_PER_RD;
            S_PER_WT:    o_cmd.op = OP_PER_WT;
            S_PER_CHK:   o_cmd.op = OP_PER_CHK;
            S_MOD:       o_cmd.op = OP_MOD;
            S_SCAN_INIT: o_cmd.op = OP_SCAN_INIT;
            S_SCAN:      o_cmd.op = OP_SCAN;
            S_R0:        o_cmd.op = OP_R0;
            S_R1:        o_cmd.op = OP_R1;
            S_R2:        o_cmd.op = OP_R2;
            S_V0:        o_cmd.op = OP_V0;
            S_V1:        o_cmd.op = OP_V1;
            S_V2:        o_cmd.op = OP_V2;
            S_MUL0:      o_cmd.op = OP_MUL0;
            S_MUL1:      o_cmd.op = OP_MUL1;
            S_DIV:       o_cmd.op = OP_DIV;
            S_FIN:       o_cmd.op = OP_FIN;
            S_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.op    = OP_OUT;
            end
            default:     o_cmd.op = OP_IDLE;
        endcase
    end

endmodule

@@ src/lti_dp.sv @@
// ----------------------------------------------------------------------------
// lti_dp
// Datapath: timeline memories, configuration, phase remainder, segment
// search and the serial multiply/divide used for interpolation.
// ----------------------------------------------------------------------------
module lti_dp
    import lti_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_in_fire,
    input  logic [1:0]            i_func,
    input  logic [ROW_AW-1:0]     i_row_index,
    input  logic [FW-1:0]         i_field_slot,
    input  logic [TW-1:0]         i_row_time,
    input  logic [ST_W-1:0]       i_row_status,
    input  logic signed [VW-1:0]  i_field_value,
    input  logic [NOW_W-1:0]      i_now,
    input  logic                  i_cfg_fire,
    input  logic [CFG_AW-1:0]     i_cfg_index,
    input  logic [CFG_DW-1:0]     i_cfg_data,
    input  logic                  i_out_fire,
    output logic [FW-1:0]         o_field_id,
    output logic [2:0]            o_meas_code,
    output logic signed [VW-1:0]  o_measured_value,
    output logic [NOW_W-1:0]      o_timestamp,
    output logic [7:0]            o_source_tag,
    output logic                  o_last
);

    // Configuration
    logic [RC_W-1:0] r_row_count;
    logic            r_ien;
    logic [NF-1:0]   r_mask;
    logic [7:0]      r_sensor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= RC_W'(1);
            r_ien       <= 1'b0;
            r_mask      <= '0;
            r_sensor    <= '0;
        end else if (i_cfg_fire) begin
            case (i_cfg_index)
                REG_ROW_COUNT: r_row_count <= i_cfg_data[RC_W-1:0];
                REG_INTERP:    r_ien       <= i_cfg_data[0];
                REG_MASK:      r_mask      <= i_cfg_data[NF-1:0];
                REG_SENSOR:    r_sensor    <= i_cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    logic [RC_W-1:0] rc;
    always_comb begin
        if (r_row_count == '0) begin
            rc = RC_W'(1);
        end else if (r_row_count > RC_W'(ROWS)) begin
            rc = RC_W'(ROWS);
        end else begin
            rc = r_row_count;
        end
    end
    logic [ROW_AW-1:0] last_row;
    assign last_row = ROW_AW'(rc - RC_W'(1));

    // Start state
    logic             r_started;
    logic [NOW_W-1:0] r_start;
    logic [NOW_W-1:0] r_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_start   <= '0;
        end else if (i_in_fire && i_func == FUNC_START) begin
            r_started <= 1'b1;
            r_start   <= i_now;
        end
    end

    // Working registers
    logic [TW-1:0]         r_period, r_phase, r_rem, r_tprev, r_t0, r_t1, r_seg, r_num;
    logic                  r_pz;
    logic [NOW_W-1:0]      r_dvd;
    logic [CNT_W-1:0]      r_cnt;
    logic [ROW_AW-1:0]     r_i0, r_k, r_kd;
    logic                  r_active, r_kv, r_found;
    logic [ST_W-1:0]       r_st0, r_st1;
    logic signed [VW-1:0]  r_v0;
    logic [DIF_W-1:0]      r_dif;
    logic                  r_neg;
    logic [PROD_W-1:0]     r_prod;
    logic [FW-1:0]         r_field;
    logic [2:0]            r_code;
    logic signed [VW-1:0]  r_value;
    logic                  r_last;

    logic [ROW_AW-1:0] i1;
    assign i1 = r_pz ? '0 : r_i0 + ROW_AW'(1);

    // Timeline memories: time and status share a row; values by {row, field}.
    logic [ST_W+TW-1:0]   mem_t [ROWS];
    logic [VW-1:0]        mem_v [ROWS*8];
    logic [ST_W+TW-1:0]   r_trd;
    logic [VW-1:0]        r_vrd;
    logic [ROW_AW-1:0]    t_addr;
    logic [VAL_AW-1:0]    v_addr;

    always_comb begin
        case (i_cmd.op)
            OP_PER_RD: t_addr = last_row;
            OP_SCAN:   t_addr = r_k;
            OP_R0:     t_addr = r_i0;
            OP_R1:     t_addr = i1;
            default:   t_addr = r_i0;
        endcase
        case (i_cmd.op)
            OP_V1:   v_addr = {i1, r_field};
            default: v_addr = {r_i0, r_field};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_in_fire && i_func == FUNC_LOAD_T) begin
            mem_t[i_row_index] <= {i_row_status, i_row_time};
        end
        r_trd <= mem_t[t_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_in_fire && i_func == FUNC_LOAD_V && i_field_slot != SLOT_NONE) begin
            mem_v[{i_row_index, i_field_slot}] <= i_field_value;
        end
        r_vrd <= mem_v[v_addr];
    end

    logic [TW-1:0]   rd_time;
    logic [ST_W-1:0] rd_st;
    assign rd_time = r_trd[TW-1:0];
    assign rd_st   = r_trd[ST_W+TW-1:TW];

    // Restoring steps for the phase remainder and the quotient; both use r_rem.
    logic [TW:0]   mod_try, div_try;
    logic          mod_ge, div_ge;
    assign mod_try = {r_rem, r_dvd[NOW_W-1]};
    assign mod_ge  = mod_try >= {1'b0, r_period};
    assign div_try = {r_rem, r_prod[PROD_W-1]};
    assign div_ge  = div_try >= {1'b0, r_seg};

    // Per-field decision made once both rows are known.
    logic [2:0] code_n;
    logic       go_n;
    always_comb begin
        if (!r_mask[r_field]) begin
            code_n = MEAS_UNAVL;
        end else if (r_st0 == ROW_WARMUP) begin
            code_n = MEAS_WARMUP;
        end else if (r_st0 == ROW_STALE) begin
            code_n = MEAS_STALE;
        end else if (r_st0 != ROW_OK) begin
            code_n = MEAS_ERROR;
        end else begin
            code_n = MEAS_OK;
        end
        go_n = (code_n == MEAS_OK) && r_ien && !r_pz && (r_st1 == ROW_OK) && (r_t1 > r_t0);
    end

    logic signed [DIF_W-1:0] v1e, v0e, dif_s;
    assign v1e   = DIF_W'(signed'(r_vrd));
    assign v0e   = DIF_W'(r_v0);
    assign dif_s = v1e - v0e;

    // Rounding and saturation of the interpolated value.
    localparam int unsigned SUM_W = PROD_W + 2;
    logic [PROD_W:0]         q_rnd;
    logic signed [SUM_W-1:0] sum_s, vmax_s, vmin_s;
    logic signed [VW-1:0]    fin_v;
    always_comb begin
        q_rnd  = {1'b0, r_prod} + ((({r_rem, 1'b0}) >= {1'b0, r_seg}) ? 1'b1 : 1'b0);
        vmax_s = SUM_W'({1'b0, {(VW-1){1'b1}}});
        vmin_s = -vmax_s - SUM_W'(1);
        if (r_neg) begin
            sum_s = SUM_W'(r_v0) - signed'({1'b0, q_rnd});
        end else begin
            sum_s = SUM_W'(r_v0) + signed'({1'b0, q_rnd});
        end
        if (sum_s > vmax_s) begin
            fin_v = vmax_s[VW-1:0];
        end else if (sum_s < vmin_s) begin
            fin_v = vmin_s[VW-1:0];
        end else begin
            fin_v = sum_s[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_IDLE: begin
                if (i_in_fire && i_func == FUNC_READ) begin
                    r_now   <= i_now;
                    r_field <= '0;
                    r_code  <= MEAS_NS;
                    r_value <= '0;
                    r_last  <= 1'b1;
                end
            end
            OP_PER_RD: begin
                r_dvd <= (r_now >= r_start) ? r_now - r_start : '0;
            end
            OP_PER_WT: begin
                r_period <= (rc > RC_W'(1)) ? rd_time : '0;
            end
            OP_PER_CHK: begin
                r_pz    <= (r_period == '0);
                r_phase <= '0;
                r_i0    <= '0;
                r_rem   <= '0;
                r_cnt   <= '0;
            end
            OP_MOD: begin
                r_rem <= mod_ge ? TW'(mod_try - {1'b0, r_period}) : mod_try[TW-1:0];
                r_dvd <= {r_dvd[NOW_W-2:0], 1'b0};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            OP_SCAN_INIT: begin
                r_phase  <= r_rem;
                r_i0     <= ROW_AW'(rc - RC_W'(2));
                r_k      <= '0;
                r_active <= 1'b1;
                r_found  <= 1'b0;
                r_kv     <= 1'b0;
            end
            OP_SCAN: begin
                if (r_kv) begin
                    if (r_kd != '0 && !r_found && r_tprev <= r_phase && r_phase < rd_time) begin
                        r_found <= 1'b1;
                        r_i0    <= r_kd - ROW_AW'(1);
                    end
                    r_tprev <= rd_time;
                end
                r_kv <= r_active;
                r_kd <= r_k;
                if (r_active) begin
                    if (r_k == last_row) begin
                        r_active <= 1'b0;
                    end else begin
                        r_k <= r_k + ROW_AW'(1);
                    end
                end
            end
            OP_R1: begin
                r_t0  <= rd_time;
                r_st0 <= rd_st;
            end
            OP_R2: begin
                r_t1    <= rd_time;
                r_st1   <= rd_st;
                r_field <= '0;
            end
            OP_V1: begin
                r_v0 <= signed'(r_vrd);
            end
            OP_V2: begin
                r_code  <= code_n;
                r_value <= (code_n == MEAS_OK) ? r_v0 : '0;
                r_last  <= (r_field == FIELD_LAST);
                r_seg   <= r_t1 - r_t0;
                if (r_phase >= r_t0) begin
                    r_num <= r_phase - r_t0;
                end else begin
                    r_num <= r_t0 - r_phase;
                end
                r_dif <= dif_s[DIF_W-1] ? DIF_W'(-dif_s) : DIF_W'(dif_s);
                r_neg <= (r_phase < r_t0) ^ dif_s[DIF_W-1];
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_MUL0: begin
                r_prod <= PROD_W'(r_num * r_dif[DL_W-1:0]);
            end
            OP_MUL1: begin
                r_prod <= r_prod + (PROD_W'(r_num * r_dif[DIF_W-1:DL_W]) << DL_W);
            end
            OP_DIV: begin
                r_rem  <= div_ge ? TW'(div_try - {1'b0, r_seg}) : div_try[TW-1:0];
                r_prod <= {r_prod[PROD_W-2:0], div_ge};
                r_cnt  <= r_cnt + CNT_W'(1);
            end
            OP_FIN: begin
                r_value <= fin_v;
            end
            OP_OUT: begin
                if (i_out_fire) begin
                    r_field <= r_field + FW'(1);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.started     = r_started;
        o_sts.period_zero = (r_period == '0);
        o_sts.mod_done    = (r_cnt == CNT_W'(NOW_W - 1));
        o_sts.scan_done   = !r_active && !r_kv;
        o_sts.div_done    = (r_cnt == CNT_W'(PROD_W - 1));
        o_sts.interp_go   = go_n;
        o_sts.last_field  = r_last;
    end

    assign o_field_id       = r_field;
    assign o_meas_code      = r_code;
    assign o_measured_value = r_value;
    assign o_timestamp      = r_now;
    assign o_source_tag     = r_sensor;
    assign o_last           = r_last;

endmodule

@@ src/looped_timeline_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// looped_timeline_interpolator_top
// Looped timeline table with per-field linear interpolation.
// ----------------------------------------------------------------------------
// Load and start words are taken in one cycle each. A read word returns one
// not-started word when no start was seen, otherwise seven result words, one
// per field, the last flagged. A read runs the 64-step phase remainder and
// the segment search, which reads one row a cycle from the time memory, both
// skipped when the period is zero; then the two row reads and, per field,
// the value reads and, for an interpolated field, the serial multiply and
// 81-step divide. Input is held off while a read is in progress. No clearing
// pass is needed after reset.
module looped_timeline_interpolator_top
    import lti_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    lti_in_if.sink     i_in,
    lti_out_if.source  o_out,
    lti_cfg_if.sink    i_cfg
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready, out_valid, in_fire, out_fire, cfg_fire;

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_in.valid && in_ready;
    assign out_fire    = out_valid && o_out.ready;
    assign cfg_fire    = i_cfg.valid;

    lti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (in_fire),
        .i_in_func   (i_in.func),
        .i_out_fire  (out_fire),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid)
    );

    lti_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_in_fire        (in_fire),
        .i_func           (i_in.func),
        .i_row_index      (i_in.row_index),
        .i_field_slot     (i_in.field_slot),
        .i_row_time       (i_in.row_time_ms),
        .i_row_status     (i_in.row_status_code),
        .i_field_value    (i_in.field_value),
        .i_now            (i_in.now_ms),
        .i_cfg_fire       (cfg_fire),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_out_fire       (out_fire),
        .o_field_id       (o_out.field_id),
        .o_meas_code      (o_out.meas_code),
        .o_measured_value (o_out.measured_value),
        .o_timestamp      (o_out.timestamp_ms),
        .o_source_tag     (o_out.source_tag),
        .o_last           (o_out.last)
    );

endmodule

@@ src/lti_checker.sv @@
// ----------------------------------------------------------------------------
// lti_checker
// Port-level checks for the looped timeline interpolator.
// ----------------------------------------------------------------------------
module lti_checker
    import lti_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_func,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_out_code,
    input logic [47:0] i_out_value,
    input logic        i_out_last
);

    // A word waiting at the output holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value))
        else $error("output word changed while stalled");

    // A read blocks new input until all its words are out.
    a_read_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_func == FUNC_READ |=> !i_in_ready)
        else $error("input taken during a read");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result is pending");

    // The not-started answer is a single word.
    a_ns_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_code == MEAS_NS |-> i_out_last)
        else $error("not-started word without last");

endmodule

bind looped_timeline_interpolator_top lti_checker u_lti_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_func   (i_in.func),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_code  (o_out.meas_code),
    .i_out_value (o_out.measured_value),
    .i_out_last  (o_out.last)
);

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the looped timeline interpolator. Loads random
// timeline tables, starts the clock and issues reads under several register
// settings and idling patterns; every result word is checked against an
// internal prediction of the looped phase, segment and interpolation.
// ----------------------------------------------------------------------------
module testbench;
    import lti_pkg::*;

    typedef struct {
        logic [1:0]         func;
        logic [7:0]         row_index;
        logic [2:0]         field_slot;
        logic [31:0]        row_time_ms;
        logic [2:0]         row_status_code;
        logic signed [47:0] field_value;
        logic [63:0]        now_ms;
    } t_word;

    typedef struct {
        logic [2:0]         field_id;
        logic [2:0]         meas_code;
        logic signed [47:0] measured_value;
        logic [63:0]        timestamp_ms;
        logic [7:0]         source_tag;
        logic               last;
    } t_meas;

    localparam logic signed [47:0] VAL_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] VAL_MIN = {1'b1, {47{1'b0}}};
    localparam int unsigned CYCLE_LIMIT = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lti_in_if  in_ch();
    lti_out_if out_ch();
    lti_cfg_if cfg_ch();

    looped_timeline_interpolator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    t_word pending_words[$];
    t_meas meas_queue[$];
    int    errors = 0;
    int    send_idle = 0;
    int    recv_stall = 0;
    int unsigned cycles = 0;

    // Shadow of the block's table, registers and start state.
    logic [31:0]        tab_time[ROWS];
    logic [2:0]         tab_status[ROWS];
    logic signed [47:0] tab_value[ROWS][NF];
    logic [8:0]         reg_rows = 9'd1;
    logic               reg_interp = 1'b0;
    logic [6:0]         reg_mask = 7'd0;
    logic [7:0]         reg_sensor = 8'd0;
    logic               clk_started = 1'b0;
    logic [63:0]        clk_start_ms = 64'd0;

    // Generator-side knowledge of the table, used to shape read times.
    logic [63:0] gen_start = 64'd0;
    logic [31:0] gen_period = 32'd0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_LOAD_T;
        in_ch.row_index = '0;
        in_ch.field_slot = '0;
        in_ch.row_time_ms = '0;
        in_ch.row_status_code = '0;
        in_ch.field_value = '0;
        in_ch.now_ms = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    function automatic logic signed [47:0] lerp(input logic signed [47:0] v0,
                                                input logic signed [47:0] v1,
                                                input logic [31:0] phase,
                                                input logic [31:0] t0,
                                                input logic [31:0] t1);
        logic signed [127:0] num, dif, prod, mag, seg, q, r, res;
        if (t1 <= t0)
            return v0;
        seg = $signed({96'd0, t1}) - $signed({96'd0, t0});
        num = $signed({96'd0, phase}) - $signed({96'd0, t0});
        dif = 128'(v1) - 128'(v0);
        prod = num * dif;
        mag = (prod < 0) ? -prod : prod;
        q = mag / seg;
        r = mag % seg;
        if (r >= seg - r)
            q = q + 1;
        res = (prod < 0) ? 128'(v0) - q : 128'(v0) + q;
        if (res > 128'(VAL_MAX))
            return VAL_MAX;
        if (res < 128'(VAL_MIN))
            return VAL_MIN;
        return res[47:0];
    endfunction

    task automatic timeline_step(input t_word w);
        t_meas m;
        int unsigned rc, i0, i1;
        logic [63:0] elapsed, phase;
        logic [31:0] period;
        logic [2:0] st;
        logic signed [47:0] v;
        case (w.func)
            FUNC_LOAD_T: begin
                tab_time[w.row_index] = w.row_time_ms;
                tab_status[w.row_index] = w.row_status_code;
            end
            FUNC_LOAD_V: begin
                if (w.field_slot != SLOT_NONE)
                    tab_value[w.row_index][w.field_slot] = w.field_value;
            end
            FUNC_START: begin
                clk_start_ms = w.now_ms;
                clk_started = 1'b1;
            end
            default: begin
                m.timestamp_ms = w.now_ms;
                m.source_tag = reg_sensor;
                if (!clk_started) begin
                    m.field_id = '0;
                    m.meas_code = MEAS_NS;
                    m.measured_value = '0;
                    m.last = 1'b1;
                    meas_queue.push_back(m);
                end else begin
                    rc = reg_rows;
                    if (rc == 0)
                        rc = 1;
                    if (rc > ROWS)
                        rc = ROWS;
                    elapsed = (w.now_ms >= clk_start_ms) ? w.now_ms - clk_start_ms : 64'd0;
                    period = (rc > 1) ? tab_time[rc - 1] : 32'd0;
                    i0 = 0;
                    i1 = 0;
                    phase = 64'd0;
                    if (period != 0) begin
                        phase = elapsed % period;
                        i0 = rc - 2;
                        for (int k = 0; k + 1 < rc; k++) begin
                            if (phase >= tab_time[k] && phase < tab_time[k + 1]) begin
                                i0 = k;
                                break;
                            end
                        end
                        i1 = i0 + 1;
                    end
                    st = tab_status[i0];
                    for (int f = 0; f < NF; f++) begin
                        m.field_id = f[2:0];
                        m.last = (f == NF - 1);
                        m.measured_value = '0;
                        if (!reg_mask[f])
                            m.meas_code = MEAS_UNAVL;
                        else if (st == ROW_WARMUP)
                            m.meas_code = MEAS_WARMUP;
                        else if (st == ROW_STALE)
                            m.meas_code = MEAS_STALE;
                        else if (st != ROW_OK)
                            m.meas_code = MEAS_ERROR;
                        else begin
                            m.meas_code = MEAS_OK;
                            v = tab_value[i0][f];
                            if (reg_interp && i0 != i1 && tab_status[i1] == ROW_OK)
                                v = lerp(v, tab_value[i1][f], phase[31:0],
                                         tab_time[i0], tab_time[i1]);
                            m.measured_value = v;
                        end
                        meas_queue.push_back(m);
                    end
                end
            end
        endcase
    endtask

    // Driver: presents queued words, idling at random between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid)
                timeline_step('{in_ch.func, in_ch.row_index, in_ch.field_slot,
                                in_ch.row_time_ms, in_ch.row_status_code,
                                in_ch.field_value, in_ch.now_ms});
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle) begin
                t_word w;
                w = pending_words.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.func <= w.func;
                in_ch.row_index <= w.row_index;
                in_ch.field_slot <= w.field_slot;
                in_ch.row_time_ms <= w.row_time_ms;
                in_ch.row_status_code <= w.row_status_code;
                in_ch.field_value <= w.field_value;
                in_ch.now_ms <= w.now_ms;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and in-order comparison.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall);
            if (out_ch.valid && out_ch.ready) begin
                if (meas_queue.size() == 0) begin
                    report("result word with nothing expected");
                end else begin
                    t_meas e;
                    e = meas_queue.pop_front();
                    if (out_ch.field_id !== e.field_id)
                        report($sformatf("field_id %0d, want %0d", out_ch.field_id,
                                         e.field_id));
                    if (out_ch.meas_code !== e.meas_code)
                        report($sformatf("meas_code %0d, want %0d (field %0d)",
                                         out_ch.meas_code, e.meas_code, e.field_id));
                    if (out_ch.measured_value !== e.measured_value)
                        report($sformatf("measured_value %0d, want %0d (field %0d)",
                                         out_ch.measured_value, e.measured_value,
                                         e.field_id));
                    if (out_ch.timestamp_ms !== e.timestamp_ms)
                        report($sformatf("timestamp_ms %h, want %h", out_ch.timestamp_ms,
                                         e.timestamp_ms));
                    if (out_ch.source_tag !== e.source_tag)
                        report($sformatf("source_tag %h, want %h", out_ch.source_tag,
                                         e.source_tag));
                    if (out_ch.last !== e.last)
                        report($sformatf("last %b, want %b", out_ch.last, e.last));
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout with %0d words expected", meas_queue.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic signed [47:0] rand_value();
        case ($urandom_range(7))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2, 3: return $signed(48'(rand64()));
            default: return 48'(signed'(20'($urandom())) * 65536);
        endcase
    endfunction

    function automatic logic [2:0] rand_status();
        return ($urandom_range(3) != 0) ? ROW_OK : 3'($urandom_range(1, 7));
    endfunction

    task automatic push_word(input logic [1:0] func, input logic [7:0] row,
                             input logic [2:0] slot, input logic [31:0] t,
                             input logic [2:0] st, input logic signed [47:0] v,
                             input logic [63:0] now);
        t_word w;
        w = '{func, row, slot, t, st, v, now};
        pending_words.push_back(w);
    endtask

    task automatic push_row(input int unsigned row, input logic [31:0] t, input logic [2:0] st);
        push_word(FUNC_LOAD_T, row[7:0], 3'($urandom()), t, st, rand_value(), rand64());
        for (int f = 0; f < NF; f++)
            push_word(FUNC_LOAD_V, row[7:0], f[2:0], 32'($urandom()), 3'($urandom()),
                      rand_value(), rand64());
    endtask

    // Fills rows 0..rows-1 completely. Kind 0 ascending, 1 all zero, 2 scrambled.
    task automatic fill_timeline(input int unsigned rows, input int kind);
        logic [31:0] t;
        t = 32'd0;
        for (int unsigned r = 0; r < rows; r++) begin
            if (kind == 1)
                t = 32'd0;
            else if (kind == 2)
                t = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(5000));
            else if (r != 0)
                t = t + $urandom_range(1, 1000);
            push_row(r, t, rand_status());
        end
        gen_period = (kind == 1 || rows < 2) ? 32'd1 : t;
        if (gen_period == 0)
            gen_period = 32'd1;
    endtask

    task automatic push_read();
        logic [63:0] now;
        case ($urandom_range(15))
            0: now = rand64();
            1: now = gen_start - $urandom_range(1, 100);
            2: now = 64'hFFFF_FFFF_FFFF_FFFF;
            default: now = gen_start + 64'($urandom_range(0, 4 * gen_period + 3));
        endcase
        push_word(FUNC_READ, 8'($urandom()), 3'($urandom()), $urandom(), 3'($urandom()),
                  rand_value(), now);
    endtask

    task automatic push_start(input logic [63:0] now);
        gen_start = now;
        push_word(FUNC_START, 8'($urandom()), 3'($urandom()), $urandom(), 3'($urandom()),
                  rand_value(), now);
    endtask

    task automatic random_words(input int unsigned rows, input int n);
        int unsigned r;
        for (int i = 0; i < n; i++) begin
            r = (rows > 1) ? $urandom_range(rows - 1) : 0;
            case ($urandom_range(19))
                0, 1: push_start(($urandom_range(3) == 0) ? rand64() : 64'($urandom()));
                2, 3, 4: push_word(FUNC_LOAD_V, r[7:0], 3'($urandom_range(7)), $urandom(),
                                   3'($urandom()), rand_value(), rand64());
                5: push_row($urandom_range(255), $urandom(), 3'($urandom()));
                6: push_word(FUNC_LOAD_T, r[7:0], 3'($urandom()),
                             (r == 0) ? 32'd0 : $urandom_range(gen_period),
                             rand_status(), rand_value(), rand64());
                default: push_read();
            endcase
        end
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_ROW_COUNT: reg_rows = data[8:0];
            REG_INTERP:    reg_interp = data[0];
            REG_MASK:      reg_mask = data[6:0];
            default:       reg_sensor = data[7:0];
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || in_ch.valid || meas_queue.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Register settings per phase: row count, interpolation, field mask, sensor id.
    int unsigned ph_rows[8]   = '{4, 0, 8, 256, 511, 2, 16, 5};
    bit          ph_interp[8] = '{1, 1, 1, 1, 0, 1, 1, 0};
    int unsigned ph_mask[8]   = '{127, 85, 127, 127, 42, 127, 127, 127};
    int unsigned ph_sensor[8] = '{255, 90, 17, 128, 0, 1, 201, 60};
    int          ph_kind[8]   = '{0, 0, 0, 0, 2, 1, 2, 0};
    int          ph_count[8]  = '{60, 40, 70, 12, 10, 50, 80, 70};

    initial begin
        int unsigned eff;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults: read before any start, then a single-row table.
        push_read();
        push_row(0, 32'hFFFF_FFFF, ROW_OK);
        push_word(FUNC_LOAD_V, 8'd0, SLOT_NONE, 32'd0, 3'd0, VAL_MAX, 64'd0);
        push_start(64'hFFFF_FFFF_FFFF_FFFF);
        push_word(FUNC_READ, 8'hFF, 3'd7, 32'hFFFF_FFFF, 3'd7, VAL_MIN, 64'd0);
        push_word(FUNC_READ, 8'd0, 3'd0, 32'd0, 3'd0, 48'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        drain();

        for (int p = 0; p < 8; p++) begin
            send_idle = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 28 : 46) : 0;
            recv_stall = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 3) ? 28 : 46) : 0;
            write_reg(REG_ROW_COUNT, 16'(ph_rows[p]));
            write_reg(REG_INTERP, 16'(ph_interp[p]));
            write_reg(REG_MASK, 16'(ph_mask[p]));
            write_reg(REG_SENSOR, 16'(ph_sensor[p]));
            eff = (ph_rows[p] == 0) ? 1 : (ph_rows[p] > ROWS ? ROWS : ph_rows[p]);
            fill_timeline(eff, ph_kind[p]);
            if (p == 0) begin
                // Extremes between ok rows, then every fault status on row 0 and a stale row 1.
                push_row(0, 32'd0, ROW_OK);
                push_row(1, 32'd10, ROW_OK);
                for (int f = 0; f < NF; f++) begin
                    push_word(FUNC_LOAD_V, 8'd0, f[2:0], 32'd0, 3'd0,
                              (f % 2) ? VAL_MIN : VAL_MAX, 64'd0);
                    push_word(FUNC_LOAD_V, 8'd1, f[2:0], 32'd0, 3'd0,
                              (f % 2) ? VAL_MAX : VAL_MIN, 64'd0);
                end
                push_start(64'd1000);
                push_word(FUNC_READ, 8'd0, 3'd0, 32'd0, 3'd0, 48'd0, 64'd1005);
                push_word(FUNC_READ, 8'd0, 3'd0, 32'd0, 3'd0, 48'd0, 64'd999);
                for (int s = 1; s < 8; s++) begin
                    push_word(FUNC_LOAD_T, 8'd0, 3'd0, 32'd0, s[2:0], 48'd0, 64'd0);
                    push_word(FUNC_READ, 8'd0, 3'd0, 32'd0, 3'd0, 48'd0, 64'd1003);
                end
                push_word(FUNC_LOAD_T, 8'd0, 3'd0, 32'd0, ROW_OK, 48'd0, 64'd0);
                push_word(FUNC_LOAD_T, 8'd1, 3'd0, 32'd10, ROW_STALE, 48'd0, 64'd0);
                push_word(FUNC_READ, 8'd0, 3'd0, 32'd0, 3'd0, 48'd0, 64'd1007);
            end
            push_start(($urandom_range(3) == 0) ? rand64() : 64'($urandom()));
            random_words(eff, ph_count[p]);
            drain();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ looped_timeline_interpolator_top.f @@
src/lti_pkg.sv
src/lti_if.sv
src/lti_ctrl.sv
src/lti_dp.sv
src/looped_timeline_interpolator_top.sv
src/lti_checker.sv
sim/testbench.sv
